/* rtl/i2cee_pkg.sv */
// ============================================================================
// i2cee_pkg
// Shared constants, types and helpers of the I2C slave EEPROM back end.
// ============================================================================
package i2cee_pkg;

   localparam int MEM_DEPTH  = 256;
   localparam int ADDR_BYTES = 2;
   localparam int BYTE_W     = 8;
   localparam int PTR_W      = $clog2(MEM_DEPTH);
   localparam int ABYTE_CNT  = 2;
   localparam int CNT_W      = 2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Bus events as they arrive on the request channel.
   localparam logic [1:0] EV_START = 2'd0;
   localparam logic [1:0] EV_ACK   = 2'd1;
   localparam logic [1:0] EV_NACK  = 2'd2;
   localparam logic [1:0] EV_STOP  = 2'd3;

   // Classified commands handed to the back end.
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_ACK   = 2'd1;
   localparam logic [1:0] OP_END   = 2'd2;

   typedef struct packed {
      logic [1:0]        op;
      logic [BYTE_W-1:0] rx_byte;
      logic              is_read;
      logic              addr_hit;
   } cmd_type;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(MEM_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

endpackage

/* rtl/i2cee_req_if.sv */
// ============================================================================
// i2cee_req_if
// Bus event channel: one word per I2C event with its received byte and flags.
// ============================================================================
interface i2cee_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] event_kind;
   logic [7:0] rx_byte;
   logic       is_read;
   logic       addr_hit;

   modport source (output valid, output event_kind, output rx_byte,
                   output is_read, output addr_hit, input ready);
   modport sink   (input valid, input event_kind, input rx_byte,
                   input is_read, input addr_hit, output ready);
endinterface

/* rtl/i2cee_rsp_if.sv */
// ============================================================================
// i2cee_rsp_if
// Result channel: transmit byte request and address mismatch flag.
// ============================================================================
interface i2cee_rsp_if;
   logic       valid;
   logic       ready;
   logic       tx_valid;
   logic [7:0] tx_byte;
   logic       no_match_error;

   modport source (output valid, output tx_valid, output tx_byte,
                   output no_match_error, input ready);
   modport sink   (input valid, input tx_valid, input tx_byte,
                   input no_match_error, output ready);
endinterface

/* rtl/i2cee_front.sv */
// ============================================================================
// i2cee_front
// Accepts bus event words, classifies them into commands and buffers them in
// a short queue towards the back end.
// ============================================================================
module i2cee_front (
   input  logic               clock,
   input  logic               reset,
   i2cee_req_if.sink          req_chan,
   output logic               cmd_valid,
   input  logic               cmd_ready,
   output i2cee_pkg::cmd_type cmd
);
   import i2cee_pkg::*;

   cmd_type           q_ff [QUEUE_DEPTH];
   logic [QIDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic [QIDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   cmd_type           new_cmd;
   logic              push, pop;

   // Nack and stop have the same effect, so both become an end command.
   always_comb begin
      new_cmd.rx_byte  = req_chan.rx_byte;
      new_cmd.is_read  = req_chan.is_read;
      new_cmd.addr_hit = req_chan.addr_hit;
      case (req_chan.event_kind)
         EV_START: new_cmd.op = OP_START;
         EV_ACK:   new_cmd.op = OP_ACK;
         EV_NACK:  new_cmd.op = OP_END;
         default:  new_cmd.op = OP_END;
      endcase
   end

   assign req_chan.ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push           = req_chan.valid && req_chan.ready;
   assign cmd_valid      = (count_ff != '0);
   assign pop            = cmd_valid && cmd_ready;
   assign cmd            = q_ff[rd_idx_ff];

   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      count_in  = count_ff;
      if (push) begin
         wr_idx_in = (wr_idx_ff == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_idx_ff + QIDX_W'(1);
      end
      if (pop) begin
         rd_idx_in = (rd_idx_ff == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_idx_ff + QIDX_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_idx_ff] <= new_cmd;
      end
   end

endmodule

/* rtl/i2cee_back.sv */
// ============================================================================
// i2cee_back
// Executes commands: transfer phase, pointer set-up, memory reads and writes,
// and the registered result word.
// ============================================================================
module i2cee_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   output logic               cmd_ready,
   input  i2cee_pkg::cmd_type cmd,
   i2cee_rsp_if.source        rsp_chan
);
   import i2cee_pkg::*;

   localparam logic [1:0] PH_ADDR = 2'd0;
   localparam logic [1:0] PH_GET  = 2'd1;
   localparam logic [1:0] PH_SEND = 2'd2;

   logic [1:0]        phase_ff, phase_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [BYTE_W-1:0] ab_ff [ABYTE_CNT];
   logic [BYTE_W-1:0] ab0_in, ab1_in;
   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic [15:0]       addr_word;

   logic [BYTE_W-1:0] mem [MEM_DEPTH];
   logic [MEM_DEPTH-1:0] vld_ff;
   logic [BYTE_W-1:0] rd_ff;
   logic              rd_vld_ff;

   logic              out_valid_ff, out_valid_in;
   logic              tx_valid_ff;
   logic              err_ff, err_in;
   logic              take, do_read, do_write, ab_write;

   assign cmd_ready = !out_valid_ff || rsp_chan.ready;
   assign take      = cmd_valid && cmd_ready;
   assign ab_write  = take && (cmd.op == OP_ACK) && (phase_ff == PH_GET) &&
                      (count_ff < CNT_W'(ADDR_BYTES));

   // New pointer bytes; the byte not written this time keeps its older value.
   assign ab0_in    = (ab_write && count_ff == CNT_W'(0)) ? cmd.rx_byte : ab_ff[0];
   assign ab1_in    = (ab_write && count_ff == CNT_W'(1)) ? cmd.rx_byte : ab_ff[1];
   assign addr_word = (ADDR_BYTES >= 2) ? {ab0_in, ab1_in} : {8'h00, ab0_in};

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      ptr_in   = ptr_ff;
      do_read  = 1'b0;
      do_write = 1'b0;
      err_in   = 1'b0;
      if (take) begin
         case (cmd.op)
            OP_START: begin
               phase_in = PH_ADDR;
            end
            OP_ACK: begin
               case (phase_ff)
                  PH_ADDR: begin
                     if (!cmd.addr_hit) begin
                        err_in = 1'b1;
                     end else if (cmd.is_read) begin
                        phase_in = PH_SEND;
                        do_read  = 1'b1;
                        ptr_in   = next_ptr(ptr_ff);
                     end else begin
                        count_in = '0;
                        phase_in = PH_GET;
                     end
                  end
                  PH_GET: begin
                     if (count_ff < CNT_W'(ADDR_BYTES)) begin
                        count_in = count_ff + CNT_W'(1);
                        ptr_in   = addr_word[PTR_W-1:0];
                     end else begin
                        do_write = 1'b1;
                        ptr_in   = next_ptr(ptr_ff);
                     end
                  end
                  PH_SEND: begin
                     do_read = 1'b1;
                     ptr_in  = next_ptr(ptr_ff);
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
               count_in = '0;
               phase_in = PH_ADDR;
            end
         endcase
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (take) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_ADDR;
         count_ff     <= '0;
         ab_ff[0]     <= '0;
         ab_ff[1]     <= '0;
         ptr_ff       <= '0;
         vld_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         ab_ff[0]     <= ab0_in;
         ab_ff[1]     <= ab1_in;
         ptr_ff       <= ptr_in;
         out_valid_ff <= out_valid_in;
         if (do_write) begin
            vld_ff[ptr_ff] <= 1'b1;
         end
      end
   end

   // Memory port and result word; an entry never written reads as zero.
   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[ptr_ff] <= cmd.rx_byte;
      end
      if (do_read) begin
         rd_ff     <= mem[ptr_ff];
         rd_vld_ff <= vld_ff[ptr_ff];
      end
      if (take) begin
         tx_valid_ff <= do_read;
         err_ff      <= err_in;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.tx_valid       = tx_valid_ff;
   assign rsp_chan.tx_byte        = (tx_valid_ff && rd_vld_ff) ? rd_ff : '0;
   assign rsp_chan.no_match_error = err_ff;

endmodule

/* rtl/i2c_slave_eeprom_backend_unit.sv */
// ============================================================================
// i2c_slave_eeprom_backend_unit
// Byte-level back end of an EEPROM-like I2C slave with a 256-byte memory.
// ============================================================================
// Each bus event word (start, ack, nack, stop) yields exactly one result word.
// The block takes one event word per cycle and delivers one result word per
// cycle when the result side keeps up. An accepted event word is first written
// into the two-entry command queue and is then executed by the back end,
// which places its result word in the result register. Each word makes at
// most one memory access. While the result side stalls, the result
// register and the queue hold three words before the event side is stalled.
// The memory reads as zero after reset through per-byte valid flags, so no
// clearing pass is needed and the block accepts events from the first cycle
// after reset.
module i2c_slave_eeprom_backend_unit (
   input  logic        clock,
   input  logic        reset,
   i2cee_req_if.sink   req_chan,
   i2cee_rsp_if.source rsp_chan
);
   import i2cee_pkg::*;

   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd;

   i2cee_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   i2cee_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp_chan  (rsp_chan)
   );

endmodule
